// File: hw/rtl/mts_pkg.sv
// shared types and constants for the min tracking stack
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int DEPTH_W     = 6;

    localparam logic signed [DATA_W-1:0] EMPTY_READ = 32'sh7FFF_FFFF;

    // command codes, code 3 behaves as a peek
    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_PEEK = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [DATA_W-1:0] push_value;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic signed [DATA_W-1:0] min_value;
        logic [DEPTH_W-1:0]       depth;
        logic [1:0]               status;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
        logic result;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_load;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: hw/rtl/min_tracking_stack.sv
// flow: each word is captured in S_IDLE, executed in S_EXEC and its result
// registered from S_DONE; a pop that leaves entries also passes S_LOAD (extra store read for the new top)
// one word at a time: the next word is taken only after the result leaves S_DONE,
// which an output stall can hold; the entry stores have a single registered read port
// reset: synchronous, active low; the stack comes up empty, stores unset
// top level of the min tracking stack; depends on mts_pkg, mts_ctrl, mts_dp
`timescale 1ns / 1ps
`default_nettype none

module min_tracking_stack (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire mts_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output mts_pkg::t_out_word      o_out_word
);
    import mts_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    mts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    mts_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .o_out_word (o_out_word)
    );

endmodule

`default_nettype wire

// File: hw/rtl/mts_ctrl.sv
// controller for the min tracking stack: sequences one word at a time
// depends on mts_pkg
`timescale 1ns / 1ps
`default_nettype none

module mts_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    input  wire mts_pkg::t_dp_sts i_sts,
    output mts_pkg::t_dp_cmd     o_cmd
);
    import mts_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd         = '0;
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec    = (r_state == S_EXEC);
        o_cmd.load    = (r_state == S_LOAD);
        o_cmd.result  = (r_state == S_DONE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // a new word replaces the one leaving in the same cycle
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= i_sts.need_load ? S_LOAD : S_DONE;
                end
                S_LOAD: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/mts_dp.sv
// datapath for the min tracking stack: entry stores, cached top entry,
// entry count and output register; depends on mts_pkg
`timescale 1ns / 1ps
`default_nettype none

module mts_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mts_pkg::t_in_word i_in_word,
    input  wire mts_pkg::t_dp_cmd  i_cmd,
    output mts_pkg::t_dp_sts       o_sts,
    output mts_pkg::t_out_word     o_out_word
);
    import mts_pkg::*;

    logic signed [DATA_W-1:0] r_val_mem [STACK_DEPTH];
    logic signed [DATA_W-1:0] r_min_mem [STACK_DEPTH];

    t_in_word                 r_in;
    logic [CNT_W-1:0]         r_count;
    logic signed [DATA_W-1:0] r_top_val;
    logic signed [DATA_W-1:0] r_top_min;
    logic signed [DATA_W-1:0] r_rd_val;
    logic signed [DATA_W-1:0] r_rd_min;
    logic [1:0]               r_status;
    t_out_word                r_out;

    logic                     is_push;
    logic                     is_pop;
    logic                     full;
    logic                     empty;
    logic signed [DATA_W-1:0] new_min;
    logic [CNT_W-1:0]         refill_idx;
    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        rd_addr;

    assign is_push    = (r_in.cmd == CMD_PUSH);
    assign is_pop     = (r_in.cmd == CMD_POP);
    assign full       = (r_count >= CNT_W'(STACK_DEPTH));
    assign empty      = (r_count == '0);
    // the new entry's value wins on a tie
    assign new_min    = (!empty && (r_top_min < r_in.push_value)) ?
                        r_top_min : r_in.push_value;
    assign refill_idx = r_count - CNT_W'(2);
    assign wr_addr    = r_count[ADDR_W-1:0];
    assign rd_addr    = refill_idx[ADDR_W-1:0];

    // a pop that leaves entries needs the new top read back from the stores
    assign o_sts.need_load = is_pop && (r_count > CNT_W'(1));
    assign o_out_word      = r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && is_push && !full) begin
            r_val_mem[wr_addr] <= r_in.push_value;
            r_min_mem[wr_addr] <= new_min;
        end
        if (i_cmd.exec) begin
            r_rd_val <= r_val_mem[rd_addr];
            r_rd_min <= r_min_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            if (is_push && !full) begin
                r_count <= r_count + CNT_W'(1);
            end else if (is_pop && !empty) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_word;
        end
        if (i_cmd.exec) begin
            priority if (is_push) begin
                r_status <= full ? ST_FULL : ST_OK;
                if (!full) begin
                    r_top_val <= r_in.push_value;
                    r_top_min <= new_min;
                end
            end else if (is_pop) begin
                r_status <= empty ? ST_EMPTY : ST_OK;
            end else begin
                r_status <= ST_OK;
            end
        end
        if (i_cmd.load) begin
            r_top_val <= r_rd_val;
            r_top_min <= r_rd_min;
        end
        if (i_cmd.result) begin
            r_out.top_value <= empty ? EMPTY_READ : r_top_val;
            r_out.min_value <= empty ? EMPTY_READ : r_top_min;
            r_out.depth     <= DEPTH_W'(r_count);
            r_out.status    <= r_status;
        end
    end

endmodule

`default_nettype wire

// File: bench/mts_checker.sv
// checker for the min tracking stack: watches both word channels, predicts
// each result from its own copy of the stack and compares field by field
// depends on mts_pkg
`timescale 1ns / 1ps

module mts_checker
    import mts_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_stall,
    input  wire t_in_word  i_in_word,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_stall,
    input  wire t_out_word i_out_word,
    output int             o_pending,
    output int             o_fail_count
);

    localparam int PRINT_CAP = 50;

    logic signed [DATA_W-1:0] stack_vals [STACK_DEPTH];
    logic signed [DATA_W-1:0] stack_mins [STACK_DEPTH];
    int                       held;
    t_out_word                expected_q[$];
    int                       mismatch_total;
    int                       words_checked;

    initial begin
        held           = 0;
        mismatch_total = 0;
        words_checked  = 0;
    end

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        // keep the log short when the block is badly broken
        if (mismatch_total < PRINT_CAP) begin
            $display("[%0t] word %0d: %s is %0h, expected %0h",
                     $realtime, words_checked, field, got, want);
        end
        mismatch_total++;
    endtask

    // applies one command to the shadow stack and returns the result word
    function automatic t_out_word apply_command(input t_in_word w);
        t_out_word                r;
        logic signed [DATA_W-1:0] run_min;
        r.status = ST_OK;
        if (w.cmd == CMD_PUSH) begin
            if (held >= STACK_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                run_min = w.push_value;
                if (held > 0 && stack_mins[held-1] < run_min) begin
                    run_min = stack_mins[held-1];
                end
                stack_vals[held] = w.push_value;
                stack_mins[held] = run_min;
                held++;
            end
        end else if (w.cmd == CMD_POP) begin
            if (held == 0) begin
                r.status = ST_EMPTY;
            end else begin
                held--;
            end
        end
        // peek and the spare code leave the stack alone
        if (held == 0) begin
            r.top_value = EMPTY_READ;
            r.min_value = EMPTY_READ;
        end else begin
            r.top_value = stack_vals[held-1];
            r.min_value = stack_mins[held-1];
        end
        r.depth = DEPTH_W'(held);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            held = 0;
            expected_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected word, top_value", i_out_word.top_value, '0);
                end else begin
                    want = expected_q.pop_front();
                    if (i_out_word.top_value !== want.top_value)
                        report_mismatch("top_value", i_out_word.top_value, want.top_value);
                    if (i_out_word.min_value !== want.min_value)
                        report_mismatch("min_value", i_out_word.min_value, want.min_value);
                    if (i_out_word.depth !== want.depth)
                        report_mismatch("depth", DATA_W'(i_out_word.depth), DATA_W'(want.depth));
                    if (i_out_word.status !== want.status)
                        report_mismatch("status", DATA_W'(i_out_word.status),
                                        DATA_W'(want.status));
                end
                words_checked++;
            end
            if (i_in_valid && !i_in_stall) begin
                expected_q.push_back(apply_command(i_in_word));
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= mismatch_total;
    end

endmodule

// File: bench/tb_min_tracking_stack.sv
// top of the min tracking stack bench: clock, reset, command stimulus with
// random idling on both sides, watchdog and verdict
// depends on mts_pkg, min_tracking_stack and mts_checker
`timescale 1ns / 1ps

module tb_min_tracking_stack;
    import mts_pkg::*;

    localparam logic [1:0] CMD_SPARE  = 2'd3;
    localparam int         ITEM_COUNT = 1450;
    localparam int         IDLE_LIMIT = 3000;
    localparam int         LONG_HOLD  = 150;
    localparam int         DRAIN_WAIT = 12;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_word out_word;
    logic      calm      = 1'b0;

    int pending;
    int fail_count;
    int sent      = 0;
    int n_push    = 0;
    int n_pop     = 0;
    int n_peek    = 0;
    int overfills = 0;
    int overdrains = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    min_tracking_stack i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    mts_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // offers one command word and waits until it is taken
    task automatic put_word(input logic [1:0] cmd, input logic signed [DATA_W-1:0] value);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid           <= 1'b1;
        in_word.cmd        <= cmd;
        in_word.push_value <= value;
        do @(posedge clk); while (!(in_valid && !in_stall));
        sent++;
        case (cmd)
            CMD_PUSH: n_push++;
            CMD_POP:  n_pop++;
            default:  n_peek++;
        endcase
    endtask

    // extremes and small values so ties and new minimums come up often
    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = 32'sh7FFF_FFFF;
            1:       v = 32'sh8000_0000;
            2, 3: begin
                v = $urandom_range(0, 15);
                v = v - 8;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] pick_cmd(input int mode);
        int r;
        r = $urandom_range(0, 9);
        case (mode)
            2: begin
                if (r < 7) return CMD_PUSH;
                if (r < 9) return CMD_POP;
                return CMD_PEEK;
            end
            3: begin
                if (r < 2) return CMD_PUSH;
                if (r < 8) return CMD_POP;
                return CMD_PEEK;
            end
            default: begin
                if (r < 4) return CMD_PUSH;
                if (r < 8) return CMD_POP;
                if (r < 9) return CMD_PEEK;
                return CMD_SPARE;
            end
        endcase
    endfunction

    // receiver: random hold before each word outside calm stretches, one long hold to back up the block
    initial begin : out_side
        int hold;
        int taken;
        taken = 0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (taken == 300) begin
                hold = LONG_HOLD;
            end else if (calm) begin
                hold = 0;
            end else begin
                hold = $urandom_range(0, 8);
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
            taken++;
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial begin : in_side
        int seg;
        int mode;
        int len;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stack, spare code, extreme values, ties and pops past empty
        put_word(CMD_PEEK, 32'sh0);
        put_word(CMD_POP, 32'sh1234_5678);
        put_word(CMD_SPARE, 32'shFFFF_FFFF);
        put_word(CMD_PUSH, 32'sh7FFF_FFFF);
        put_word(CMD_PEEK, 32'sh8000_0000);
        put_word(CMD_PUSH, 32'sh8000_0000);
        put_word(CMD_PUSH, 32'sh0);
        put_word(CMD_PUSH, -32'sd1);
        put_word(CMD_PUSH, 32'sh7FFF_FFFF);
        put_word(CMD_SPARE, 32'shA5A5_A5A5);
        repeat (5) put_word(CMD_POP, 32'sh5A5A_5A5A);
        put_word(CMD_POP, 32'sh0);
        put_word(CMD_PUSH, 32'sd5);
        put_word(CMD_PUSH, 32'sd5);
        put_word(CMD_PUSH, 32'sd3);
        put_word(CMD_PUSH, 32'sd7);
        put_word(CMD_POP, 32'sh0);
        put_word(CMD_POP, 32'sh0);
        put_word(CMD_PEEK, 32'sh0);
        put_word(CMD_POP, 32'sh0);
        put_word(CMD_POP, 32'sh0);

        // random segments; the first two fill past capacity and drain past empty
        seg = 0;
        while (sent < ITEM_COUNT) begin
            calm = ($urandom_range(0, 4) == 0);
            mode = (seg < 2) ? seg : $urandom_range(0, 4);
            case (mode)
                0: begin
                    len = $urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 4);
                    repeat (len) put_word(CMD_PUSH, pick_value());
                    overfills++;
                end
                1: begin
                    len = $urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 4);
                    repeat (len) put_word(CMD_POP, pick_value());
                    overdrains++;
                end
                default: begin
                    len = $urandom_range(10, 40);
                    repeat (len) put_word(pick_cmd(mode), pick_value());
                end
            endcase
            seg++;
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("run covered %0d commands: %0d pushes, %0d pops, %0d peeks or spare codes",
                 sent, n_push, n_pop, n_peek);
        $display("stack driven past full %0d times and past empty %0d times",
                 overfills, overdrains);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            if (pending != 0) $display("%0d expected words never arrived", pending);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/mts_pkg.sv
hw/rtl/mts_ctrl.sv
hw/rtl/mts_dp.sv
hw/rtl/min_tracking_stack.sv
bench/mts_checker.sv
bench/tb_min_tracking_stack.sv
